// File: hdl/dcc_pkg.sv
// Shared types and constants of the click / double-click classifier.
package dcc_pkg;

  // Display state codes
  localparam logic [1:0] LOOK_IDLE    = 2'd0;
  localparam logic [1:0] LOOK_HOVER   = 2'd1;
  localparam logic [1:0] LOOK_PRESSED = 2'd2;

  // Gap limit after reset, in milliseconds
  localparam logic [15:0] LIMIT_RESET = 16'd500;

  // Saturation point of the press counters
  localparam logic [1:0] PRESS_MAX = 2'd3;

  // One update tick
  typedef struct packed {
    logic        right_level;
    logic        left_level;
    logic        pointer_over;
    logic        enabled;
    logic [11:0] elapsed_ms;
  } dcc_item_t;

  // One result
  typedef struct packed {
    logic [1:0] look;
    logic       double_click;
    logic       right_click;
    logic       left_click;
  } dcc_result_t;

endpackage

// File: hdl/dcc_core.sv
// Classifier state and the per-tick update logic.
module dcc_core import dcc_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  dcc_item_t   item_i,
  input  logic [15:0] limit_i,
  output dcc_result_t result_o
);

  localparam int SUM_W = ((TIMER_BITS > 12) ? TIMER_BITS : 12) + 1;
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [SUM_W-1:0] TIMER_MAX_EXT =
    {{(SUM_W-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

  logic                  left_held_q, left_held_d;
  logic                  right_held_q, right_held_d;
  logic                  left_pending_q, left_pending_d;
  logic                  right_pending_q, right_pending_d;
  logic [1:0]            left_presses_q, left_presses_d;
  logic [1:0]            right_presses_q, right_presses_d;
  logic [TIMER_BITS-1:0] gap_timer_q, gap_timer_d;
  logic [1:0]            look_q, look_d;

  logic [SUM_W-1:0]      gap_sum;
  logic [CMP_W-1:0]      gap_ext;
  logic [CMP_W-1:0]      limit_ext;
  logic                  over_limit;

  // Saturating gap add and limit compare
  assign gap_sum = {{(SUM_W-TIMER_BITS){1'b0}}, gap_timer_q}
                 + {{(SUM_W-12){1'b0}}, item_i.elapsed_ms};
  assign limit_ext = {{(CMP_W-16){1'b0}}, limit_i};

  always_comb begin
    logic [TIMER_BITS-1:0] gap_new;
    gap_new = (gap_sum > TIMER_MAX_EXT) ? {TIMER_BITS{1'b1}}
                                        : gap_sum[TIMER_BITS-1:0];

    left_held_d     = left_held_q;
    right_held_d    = right_held_q;
    left_pending_d  = left_pending_q;
    right_pending_d = right_pending_q;
    left_presses_d  = left_presses_q;
    right_presses_d = right_presses_q;
    gap_timer_d     = gap_timer_q;
    look_d          = look_q;
    result_o        = '0;
    gap_ext         = '0;
    over_limit      = 1'b0;

    if (item_i.enabled) begin
      // Hover tracking
      if (!item_i.pointer_over) begin
        look_d = LOOK_IDLE;
      end else if (!item_i.left_level && !item_i.right_level) begin
        look_d = LOOK_HOVER;
      end

      // Count press edges
      if (item_i.left_level && !left_held_q) begin
        left_held_d    = 1'b1;
        left_presses_d = (left_presses_q == PRESS_MAX) ? PRESS_MAX
                                                       : left_presses_q + 2'd1;
        look_d         = LOOK_PRESSED;
      end
      if (item_i.right_level && !right_held_q) begin
        right_held_d    = 1'b1;
        right_presses_d = (right_presses_q == PRESS_MAX) ? PRESS_MAX
                                                         : right_presses_q + 2'd1;
        look_d          = LOOK_PRESSED;
      end

      // Advance the gap timer while a press is counted
      if (left_presses_d != 2'd0 || right_presses_d != 2'd0) begin
        gap_timer_d = gap_new;
      end else begin
        gap_timer_d = '0;
      end

      gap_ext    = {{(CMP_W-TIMER_BITS){1'b0}}, gap_timer_d};
      over_limit = gap_ext > limit_ext;

      // Decide double or single clicks
      if (left_presses_d > 2'd1 || right_presses_d > 2'd1 || over_limit) begin
        if (!over_limit) begin
          result_o.double_click = 1'b1;
        end else begin
          if (left_presses_d != 2'd0) begin
            if (left_held_d) left_pending_d = 1'b1;
            else             result_o.left_click = 1'b1;
          end
          if (right_presses_d != 2'd0) begin
            if (right_held_d) right_pending_d = 1'b1;
            else              result_o.right_click = 1'b1;
          end
        end
        left_presses_d  = '0;
        right_presses_d = '0;
        gap_timer_d     = '0;
      end

      // Releases flush queued clicks
      if (left_held_d && !item_i.left_level) begin
        left_held_d = 1'b0;
        if (left_pending_d) begin
          if (item_i.pointer_over) result_o.left_click = 1'b1;
          left_pending_d = 1'b0;
        end
      end
      if (right_held_d && !item_i.right_level) begin
        right_held_d = 1'b0;
        if (right_pending_d) begin
          if (item_i.pointer_over) result_o.right_click = 1'b1;
          right_pending_d = 1'b0;
        end
      end
    end

    result_o.look = look_d;
  end

  // Commit state on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_held_q     <= 1'b0;
      right_held_q    <= 1'b0;
      left_pending_q  <= 1'b0;
      right_pending_q <= 1'b0;
      left_presses_q  <= '0;
      right_presses_q <= '0;
      gap_timer_q     <= '0;
      look_q          <= LOOK_IDLE;
    end else if (step_i) begin
      left_held_q     <= left_held_d;
      right_held_q    <= right_held_d;
      left_pending_q  <= left_pending_d;
      right_pending_q <= right_pending_d;
      left_presses_q  <= left_presses_d;
      right_presses_q <= right_presses_d;
      gap_timer_q     <= gap_timer_d;
      look_q          <= look_d;
    end
  end

endmodule

// File: hdl/click_double_click_classifier_top.sv
// Top level: input register, classifier core, result register, limit register.
// A beat in the input register passes through the core into the result register once that register is free or read.
// Throughput: one beat per cycle while the output is not stalled; the only loop is the state update in the core.
// The input register takes a new beat while a result waits, as long as it can move on.
// Reset (rst_ni low, asynchronous) clears all state, empties both registers, and sets
// the double-click limit to 500 ms.
module click_double_click_classifier_top import dcc_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: elapsed_ms[11:0], enabled[12], pointer_over[13], left_level[14], right_level[15]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // tdata: left_click[0], right_click[1], double_click[2], look[4:3], zeros[7:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q;
  dcc_item_t   in_item_q;
  logic        out_valid_q;
  dcc_result_t out_result_q;
  dcc_result_t core_result;
  logic [15:0] limit_q;
  logic        step;

  // Move a beat from the input register to the result register
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  // Hold the double-click limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= dcc_item_t'(s_axis_tdata);
    end
  end

  dcc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .limit_i (limit_q),
    .result_o(core_result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_result_q <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_result_q};

  // A processed beat always lands in the result register
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("processed beat did not reach the result register");

  // A disabled tick reports no clicks
  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !in_item_q.enabled) |=>
      (!out_result_q.left_click && !out_result_q.right_click &&
       !out_result_q.double_click))
    else $error("disabled tick reported a click");

  // Input stalls only when both registers are full and the output is stalled
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule

// File: verif/click_double_click_classifier_top_test.sv
// Self-checking testbench for the click / double-click classifier top level.
module click_double_click_classifier_top_test;
  import dcc_pkg::*;

  localparam int     TIMER_BITS = 16;
  localparam longint TIMER_MAX  = (64'd1 << TIMER_BITS) - 1;
  localparam int     PHASES     = 6;
  localparam int     PHASE_TICKS = 300;
  localparam longint RUN_LIMIT  = 64'd12 * 64'd1_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;

  click_double_click_classifier_top #(.TIMER_BITS(TIMER_BITS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Classifier state mirrored on the testbench side
  logic [15:0] limit_ms;
  bit          l_held, r_held, l_queued, r_queued;
  logic [1:0]  l_count, r_count;
  longint      gap_ms;
  logic [1:0]  look_now;

  dcc_result_t results_due [$];
  int          errors = 0;
  bit          steady = 1'b0;
  int          stall_left = 0;
  bit          lvl_l = 1'b0, lvl_r = 1'b0;

  // Directed plan: a limit write, or a tick sent reps times, with an optional typed result
  typedef struct packed {
    logic        wr;
    logic [15:0] lim;
    logic        en;
    logic        over;
    logic        lft;
    logic        rgt;
    logic [11:0] dt;
    logic [4:0]  reps;
    logic        chk;
    logic        lc;
    logic        rc;
    logic        dc;
    logic [1:0]  look;
  } plan_row_t;

  localparam int N_PLAN = 33;
  //  wr lim        en ov l  r  dt    reps chk lc rc dc look
  localparam plan_row_t PLAN [N_PLAN] = '{
    '{0, 16'd0,     0, 0, 0, 0, 12'd0,    5'd1, 1, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     0, 1, 1, 1, 12'd4095, 5'd1, 1, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 1, 0, 0, 0, LOOK_HOVER},
    '{0, 16'd0,     1, 0, 0, 0, 12'd0,    5'd1, 1, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd10,   5'd1, 1, 0, 0, 0, LOOK_PRESSED},
    '{0, 16'd0,     1, 1, 0, 0, 12'd10,   5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd10,   5'd1, 1, 0, 0, 1, LOOK_PRESSED},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 1, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 1, 12'd4095, 5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 1, 0, 1, 0, LOOK_HOVER},
    '{0, 16'd0,     1, 1, 0, 1, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 1, 12'd4095, 5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 0, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 1, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd100,  5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd401,  5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     0, 1, 0, 0, 12'd4095, 5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd501,  5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{1, 16'd0,     0, 0, 0, 0, 12'd0,    5'd0, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd1,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{1, 16'hFFFF,  0, 0, 0, 0, 12'd0,    5'd0, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd4095, 5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd4095, 5'd16, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 1, 0, 12'd4095, 5'd1, 0, 0, 0, 0, LOOK_IDLE},
    '{0, 16'd0,     1, 1, 0, 0, 12'd0,    5'd1, 0, 0, 0, 0, LOOK_IDLE}
  };

  task automatic clear_model();
    limit_ms = LIMIT_RESET;
    l_held   = 1'b0;
    r_held   = 1'b0;
    l_queued = 1'b0;
    r_queued = 1'b0;
    l_count  = '0;
    r_count  = '0;
    gap_ms   = 0;
    look_now = LOOK_IDLE;
  endtask

  // Advance the mirrored state by one tick and return the result it reports
  function automatic dcc_result_t classify_tick(dcc_item_t it);
    dcc_result_t res;
    longint      sum;
    res = '0;
    if (it.enabled) begin
      if (!it.pointer_over) begin
        look_now = LOOK_IDLE;
      end else if (!it.left_level && !it.right_level) begin
        look_now = LOOK_HOVER;
      end
      // count press edges
      if (it.left_level && !l_held) begin
        l_held   = 1'b1;
        l_count  = (l_count == PRESS_MAX) ? PRESS_MAX : l_count + 2'd1;
        look_now = LOOK_PRESSED;
      end
      if (it.right_level && !r_held) begin
        r_held   = 1'b1;
        r_count  = (r_count == PRESS_MAX) ? PRESS_MAX : r_count + 2'd1;
        look_now = LOOK_PRESSED;
      end
      // time the gap, saturating
      if (l_count != 2'd0 || r_count != 2'd0) begin
        sum    = gap_ms + longint'(it.elapsed_ms);
        gap_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum;
      end else begin
        gap_ms = 0;
      end
      // decide double or single clicks
      if (l_count > 2'd1 || r_count > 2'd1 || gap_ms > longint'(limit_ms)) begin
        if (gap_ms <= longint'(limit_ms)) begin
          res.double_click = 1'b1;
        end else begin
          if (l_count != 2'd0) begin
            if (l_held) l_queued = 1'b1;
            else res.left_click = 1'b1;
          end
          if (r_count != 2'd0) begin
            if (r_held) r_queued = 1'b1;
            else res.right_click = 1'b1;
          end
        end
        l_count = '0;
        r_count = '0;
        gap_ms  = 0;
      end
      // release queued clicks
      if (l_held && !it.left_level) begin
        l_held = 1'b0;
        if (l_queued) begin
          if (it.pointer_over) res.left_click = 1'b1;
          l_queued = 1'b0;
        end
      end
      if (r_held && !it.right_level) begin
        r_held = 1'b0;
        if (r_queued) begin
          if (it.pointer_over) res.right_click = 1'b1;
          r_queued = 1'b0;
        end
      end
    end
    res.look = look_now;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Button sequences with random timing, plus some raw noise beats
  function automatic dcc_item_t random_tick();
    dcc_item_t   it;
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 99) < 8) return raw[15:0];
    if ($urandom_range(0, 99) < 30) lvl_l = ~lvl_l;
    if ($urandom_range(0, 99) < 25) lvl_r = ~lvl_r;
    it.enabled      = ($urandom_range(0, 99) < 92);
    it.pointer_over = ($urandom_range(0, 99) < 85);
    it.left_level   = lvl_l;
    it.right_level  = lvl_r;
    case ($urandom_range(0, 9))
      0:             raw = 32'd0;
      1, 2, 3, 4, 5: raw = $urandom_range(0, 40);
      6, 7:          raw = $urandom_range(0, 600);
      8:             raw = $urandom_range(0, 4095);
      default:       raw = 32'd4095;
    endcase
    it.elapsed_ms = raw[11:0];
    return it;
  endfunction

  // Drive one tick beat after a random gap and record its result on acceptance
  task automatic send_tick(input dcc_item_t it, input bit typed, input dcc_result_t typed_res);
    int          gap;
    dcc_result_t res;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    res = classify_tick(it);
    results_due.push_back(typed ? typed_res : res);
  endtask

  // Hold the input side idle until every result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_ms = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] phase_limit(int ph);
    logic [31:0] raw;
    raw = $urandom;
    case (ph)
      0:       return LIMIT_RESET;
      1:       return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'd50;
      4:       return 16'($urandom_range(1, 2000));
      default: return raw[15:0];
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Stall the result side at random
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Compare each result beat with the oldest recorded one
  always @(posedge clk_i) begin
    dcc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[4:0];
      if (results_due.size() == 0) begin
        $error("result beat %h with none outstanding", m_axis_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("left_click", int'(want.left_click), int'(got.left_click));
        check_field("right_click", int'(want.right_click), int'(got.right_click));
        check_field("double_click", int'(want.double_click), int'(got.double_click));
        check_field("look", int'(want.look), int'(got.look));
        check_field("zeros", 0, int'(m_axis_tdata[7:5]));
      end
    end
  end

  // Stimulus: directed plan, then random phases at several limits
  initial begin
    dcc_item_t   it;
    dcc_result_t res;
    clear_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].wr) begin
        write_limit(PLAN[i].lim);
      end else begin
        it.enabled      = PLAN[i].en;
        it.pointer_over = PLAN[i].over;
        it.left_level   = PLAN[i].lft;
        it.right_level  = PLAN[i].rgt;
        it.elapsed_ms   = PLAN[i].dt;
        res.left_click   = PLAN[i].lc;
        res.right_click  = PLAN[i].rc;
        res.double_click = PLAN[i].dc;
        res.look         = PLAN[i].look;
        repeat (PLAN[i].reps) send_tick(it, PLAN[i].chk, res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(phase_limit(ph));
      steady = (ph == 3);
      for (int k = 0; k < PHASE_TICKS; k++) send_tick(random_tick(), 1'b0, '0);
    end

    wait_drained();
    if (errors == 0) begin
      $display("click_double_click_classifier_top_test OK");
    end else begin
      $display("click_double_click_classifier_top_test NOT OK");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #(RUN_LIMIT);
    $display("click_double_click_classifier_top_test NOT OK");
    $finish;
  end

endmodule
